/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the particle pool checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define PPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define PPI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/ppi_pkg.sv */
// ----------------------------------------------------------------------------
// ppi_pkg
// Types, codes and helpers for the particle pool integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int SLOT_W = 6;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_TICK  = 1'b1;
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_RPT = 1'b1;

  // One pool entry as stored in the particle RAM.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [23:0] life;
    logic        [23:0] maxlife;
    logic        [15:0] size;
    logic signed [15:0] grav;
    logic        [31:0] color;
  } particle_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_UPD   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_RPT   = 4'b1000
  } state_e;

  // Clamp a sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

/* hw/rtl/ppi_ram.sv */
// ----------------------------------------------------------------------------
// ppi_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module ppi_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/particle_pool_integrator.sv */
// ----------------------------------------------------------------------------
// particle_pool_integrator
// Fixed pool of particles stepped by a semi-implicit Euler integrator in fixed
// point; particle state lives in one RAM, active flags in flops.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one command per transfer.
//    op_i = add stores a particle in the lowest free slot; op_i = tick
//    advances every active particle by time_step_i.
//  - Output channel (out_valid_o/out_ready_i) returns one acknowledgement per
//    add and POOL_SIZE slot reports per tick, last_o set on the final one.
//  - Config channel (cfg_valid_i/cfg_ready_o) loads gravity_accel; it is
//    always ready and must only be written while the block is idle.
//  - Add: the acknowledgement shows the cycle after the transfer.
//  - Tick: the RAM is swept once for the update, one slot per cycle through
//    the multiply pipeline (stages A to D), then swept again for reports at
//    one slot per cycle while the receiver is ready. The single RAM read
//    port sets both sweeps. No new command is taken until the last report
//    is loaded.
//  - Receiver stall: the output register holds its transfer, the report sweep
//    pauses with it; nothing is lost.
//  - Reset: all slots inactive, gravity 0. The RAM is not cleared; an entry
//    is only ever used while its slot is active.
// ----------------------------------------------------------------------------
module particle_pool_integrator #(
  parameter int POOL_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // command
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic [23:0] lifetime_i,
  input  logic [15:0] radius_i,
  input  logic signed [15:0] grav_weight_i,
  input  logic [31:0] rgba_i,
  input  logic [15:0] time_step_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic        valid_res_o,
  output logic [5:0]  slot_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [23:0] life_left_o,
  output logic [23:0] life_full_o,
  output logic [15:0] out_size_o,
  output logic [31:0] out_rgba_o,
  output logic        last_o
);

  localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int PW = $bits(ppi_pkg::particle_t);
  localparam logic [IW-1:0] LastIdx = IW'(POOL_SIZE - 1);

  // Control state
  ppi_pkg::state_e      state_q, state_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic                 issued_q, issued_d;
  logic [POOL_SIZE-1:0] active_q, active_d;
  logic signed [31:0]   grav_acc_q, grav_acc_d;
  logic [15:0]          dt_q, dt_d;

  // RAM read stage
  logic                 v_rd_q, v_rd_d;
  logic [IW-1:0]        a_rd_q, a_rd_d;

  // Update pipeline
  logic                 va_q, va_d, vb_q, vc_q, vd_q;
  logic [IW-1:0]        ia_q, ib_q, ic_q, id_q;
  ppi_pkg::particle_t   pa_q, pa_d, pb_q, pb_d, pc_q, pc_d, pd_q;
  logic signed [47:0]   pg_q;
  logic signed [48:0]   pvx_q;
  logic signed [64:0]   pdv_q;
  logic signed [48:0]   pvy_q;

  // Output register
  logic                 ov_q, ov_d;
  logic                 kind_q, kind_d, vres_q, vres_d, last_q, last_d;
  logic [5:0]           slot_q, slot_d;
  ppi_pkg::particle_t   od_q, od_d;

  // RAM ports
  logic                 ram_we, ram_re;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  logic [PW-1:0]        ram_wdata, ram_rdata;
  ppi_pkg::particle_t   rd, wpart;

  // Misc
  logic                 in_fire, out_free, a_fire, rpt_load, found;
  logic [IW-1:0]        free_idx;
  logic signed [16:0]   dt_s;
  ppi_pkg::particle_t   newp;
  logic signed [31:0]   y_new;

  assign rd          = ppi_pkg::particle_t'(ram_rdata);
  assign dt_s        = $signed({1'b0, dt_q});
  assign cfg_ready_o = 1'b1;
  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == ppi_pkg::ST_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign a_fire      = v_rd_q &&
                       ((state_q == ppi_pkg::ST_UPD) || (state_q == ppi_pkg::ST_DRAIN));
  assign rpt_load    = (state_q == ppi_pkg::ST_RPT) && v_rd_q && out_free;

  // Lowest free slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        found    = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    newp.x       = pos_x_i;
    newp.y       = pos_y_i;
    newp.vx      = vel_x_i;
    newp.vy      = vel_y_i;
    newp.life    = lifetime_i;
    newp.maxlife = lifetime_i;
    newp.size    = radius_i;
    newp.grav    = grav_weight_i;
    newp.color   = rgba_i;
  end

  // Final stage: y from the new vy, then write back
  always_comb begin
    y_new = ppi_pkg::sat32($signed({{6{pd_q.y[31]}}, pd_q.y}) +
                           $signed({{5{pvy_q[48]}}, pvy_q[48:16]}));
    wpart   = pd_q;
    wpart.y = y_new;
  end

  // Stage A: life check, first products
  always_comb begin
    pa_d      = rd;
    pa_d.life = rd.life - {8'b0, dt_q};
    va_d      = a_fire && active_q[a_rd_q] && (rd.life > {8'b0, dt_q});
  end

  // Stage B: x update; stage C: vy update
  always_comb begin
    pb_d    = pa_q;
    pb_d.x  = ppi_pkg::sat32($signed({{6{pa_q.x[31]}}, pa_q.x}) +
                             $signed({{5{pvx_q[48]}}, pvx_q[48:16]}));
    pc_d    = pb_q;
    pc_d.vy = ppi_pkg::sat32($signed({{6{pb_q.vy[31]}}, pb_q.vy}) +
                             $signed({pdv_q[64], pdv_q[64:28]}));
  end

  // Sequencer, RAM control, output register
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    issued_d   = issued_q;
    active_d   = active_q;
    grav_acc_d = grav_acc_q;
    dt_d       = dt_q;
    ram_we     = 1'b0;
    ram_waddr  = id_q;
    ram_wdata  = PW'(wpart);
    ram_re     = 1'b0;
    ram_raddr  = cnt_q;
    ov_d       = ov_q && !out_ready_i;
    kind_d     = kind_q;
    vres_d     = vres_q;
    last_d     = last_q;
    slot_d     = slot_q;
    od_d       = od_q;

    if (cfg_valid_i) begin
      grav_acc_d = $signed(cfg_data_i);
    end

    // retire during the update sweep
    if (a_fire && active_q[a_rd_q] && !(rd.life > {8'b0, dt_q})) begin
      active_d[a_rd_q] = 1'b0;
    end

    if (vd_q) begin
      ram_we = 1'b1;
    end

    unique case (state_q)
      ppi_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (op_i == ppi_pkg::OP_TICK) begin
            dt_d    = time_step_i;
            cnt_d   = '0;
            state_d = ppi_pkg::ST_UPD;
          end else begin
            ov_d   = 1'b1;
            kind_d = ppi_pkg::KIND_ACK;
            last_d = 1'b1;
            vres_d = found;
            if (found) begin
              active_d[free_idx] = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = free_idx;
              ram_wdata = PW'(newp);
              slot_d    = 6'(free_idx);
              od_d      = newp;
            end else begin
              slot_d = '0;
              od_d   = '0;
            end
          end
        end
      end
      ppi_pkg::ST_UPD: begin
        ram_re = 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = ppi_pkg::ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ppi_pkg::ST_DRAIN: begin
        if (!v_rd_q && !va_q && !vb_q && !vc_q && !vd_q) begin
          cnt_d    = '0;
          issued_d = 1'b0;
          state_d  = ppi_pkg::ST_RPT;
        end
      end
      ppi_pkg::ST_RPT: begin
        if (!issued_q && (!v_rd_q || rpt_load)) begin
          ram_re = 1'b1;
          if (cnt_q == LastIdx) begin
            issued_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (rpt_load) begin
          ov_d   = 1'b1;
          kind_d = ppi_pkg::KIND_RPT;
          vres_d = active_q[a_rd_q];
          slot_d = 6'(a_rd_q);
          last_d = (a_rd_q == LastIdx);
          od_d   = active_q[a_rd_q] ? rd : '0;
          if (a_rd_q == LastIdx) begin
            state_d = ppi_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = ppi_pkg::ST_IDLE;
    endcase

    v_rd_d = ram_re ? 1'b1 : ((a_fire || rpt_load) ? 1'b0 : v_rd_q);
    a_rd_d = ram_re ? ram_raddr : a_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ppi_pkg::ST_IDLE;
      cnt_q      <= '0;
      issued_q   <= 1'b0;
      active_q   <= '0;
      grav_acc_q <= '0;
      v_rd_q     <= 1'b0;
      va_q       <= 1'b0;
      vb_q       <= 1'b0;
      vc_q       <= 1'b0;
      vd_q       <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      issued_q   <= issued_d;
      active_q   <= active_d;
      grav_acc_q <= grav_acc_d;
      v_rd_q     <= v_rd_d;
      va_q       <= va_d;
      vb_q       <= va_q;
      vc_q       <= vb_q;
      vd_q       <= vc_q;
      ov_q       <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    dt_q   <= dt_d;
    a_rd_q <= a_rd_d;
    // stage A
    ia_q   <= a_rd_q;
    pa_q   <= pa_d;
    pg_q   <= $signed(grav_acc_q) * $signed(rd.grav);
    pvx_q  <= $signed(rd.vx) * dt_s;
    // stage B
    ib_q   <= ia_q;
    pb_q   <= pb_d;
    pdv_q  <= pg_q * dt_s;
    // stage C
    ic_q   <= ib_q;
    pc_q   <= pc_d;
    // stage D
    id_q   <= ic_q;
    pd_q   <= pc_q;
    pvy_q  <= $signed(pc_q.vy) * dt_s;
    // output
    kind_q <= kind_d;
    vres_q <= vres_d;
    last_q <= last_d;
    slot_q <= slot_d;
    od_q   <= od_d;
  end

  ppi_ram #(
    .Width (PW),
    .Depth (POOL_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign valid_res_o = vres_q;
  assign slot_o      = slot_q;
  assign out_x_o     = od_q.x;
  assign out_y_o     = od_q.y;
  assign life_left_o = od_q.life;
  assign life_full_o = od_q.maxlife;
  assign out_size_o  = od_q.size;
  assign out_rgba_o  = od_q.color;
  assign last_o      = last_q;

endmodule

/* hw/rtl/ppi_checker.sv */
// ----------------------------------------------------------------------------
// ppi_checker
// Port-level checks for the particle pool integrator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        op_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        kind_o,
  input logic        valid_res_o,
  input logic [5:0]  slot_o,
  input logic signed [31:0] out_x_o,
  input logic [23:0] life_full_o,
  input logic        last_o
);

  // stalled transfer holds
  `PPI_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_o) &&
      $stable(out_x_o) && $stable(kind_o),
    "output changed while stalled")

  // an acknowledgement always closes its command
  `PPI_ASSERT(a_ack_last,
    out_valid_o && (kind_o == ppi_pkg::KIND_ACK) |-> last_o,
    "ack without last")

  // a dropped add reports slot 0 and no data
  `PPI_ASSERT(a_drop_zero,
    out_valid_o && (kind_o == ppi_pkg::KIND_ACK) && !valid_res_o |->
      (slot_o == 6'd0) && (life_full_o == 24'd0),
    "dropped add not zeroed")

  // a tick keeps the command channel closed while it runs
  `PPI_ASSERT(a_tick_busy,
    in_valid_i && in_ready_o && (op_i == ppi_pkg::OP_TICK) |=> !in_ready_o,
    "command taken during tick")

endmodule

bind particle_pool_integrator ppi_checker u_ppi_checker (.*);
